// File: rtl/core/delr_pkg.sv
// Shared constants and types of the error log block.
package delr_pkg;

	localparam int DEF_LOG_DEPTH  = 16;
	localparam int DEF_PLACE_BITS = 4;
	localparam int DEF_KIND_BITS  = 4;

	localparam int TAG_W   = 32;
	localparam int ID_W    = 32;
	localparam int ENTRY_W = TAG_W + 2 * ID_W;
	localparam int CODE_W  = 8;
	localparam int COUNT_W = 5;
	localparam int TICK_W  = 16;

	localparam logic [TICK_W-1:0] ROTATE_RESET = 16'd1000;
	localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

	localparam logic REQ_REPORT = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// Decoded display of one log entry.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              green;
	} disp_t;

endpackage

// File: rtl/core/delr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module delr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/delr_disp.sv
// LED code decoder for one stored log entry.
module delr_disp #(
	parameter int PLACE_BITS = delr_pkg::DEF_PLACE_BITS,
	parameter int KIND_BITS  = delr_pkg::DEF_KIND_BITS
) (
	input  logic [7:0]     kind,
	input  logic [7:0]     place,
	output delr_pkg::disp_t disp
);

	logic        out_of_range;
	logic [15:0] packed_code;

	assign out_of_range = ((kind >> KIND_BITS) != 8'd0) || ((place >> PLACE_BITS) != 8'd0);
	assign packed_code  = ({8'd0, place} << KIND_BITS) | {8'd0, kind};

	always_comb begin
		if (out_of_range) begin
			disp.code  = '0;
			disp.green = 1'b0;
		end else begin
			disp.code  = packed_code[delr_pkg::CODE_W-1:0];
			disp.green = 1'b1;
		end
	end

endmodule

// File: rtl/core/dedup_error_log_led_rotator.sv
// Deduplicating error log with rotating LED display, top level.
//
// Each transaction on the s_ side is either an error report (s_tuser = 0) or a
// tick (s_tuser = 1); each yields exactly one result transaction on the m_ side
// with the LED code of the displayed entry, the green LED and the entry count.
// All entries live in one RAM of LOG_DEPTH words of 96 bits (tag, text id,
// file id) with a registered read. A report scans the held entries one read
// per cycle, overlapping each read with the compare of the previous one; a
// report that hits a held entry stops the scan early and is not written.
// A tick skips the scan and goes straight to the display read. The result
// waits until the output register is free, and no new item is taken until
// it has been loaded there. A report that matches a held entry is dropped;
// otherwise it is appended, evicting the oldest entry when the log is full.
// The RAM needs no clearing: only entries below the fill count are ever read.
// The result sits in an output register, so a new item is taken while the
// previous result still waits; rotate_ticks is written on the cfg_ port,
// which is always ready, and resets to 1000.
module dedup_error_log_led_rotator #(
	parameter int LOG_DEPTH  = delr_pkg::DEF_LOG_DEPTH,
	parameter int PLACE_BITS = delr_pkg::DEF_PLACE_BITS,
	parameter int KIND_BITS  = delr_pkg::DEF_KIND_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata, low bit up: error_kind[8], error_place[8], source_line[16],
	// text_id[32], source_file_id[32]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	// s_tuser: req_type[1]
	input  logic [0:0]  s_tuser,
	// m_tdata, low bit up: led_code[8], green_led[1], entry_count[5], zero pad[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int EW = delr_pkg::ENTRY_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_SHOW  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [delr_pkg::TICK_W-1:0] rotate_q;
	logic [delr_pkg::TICK_W-1:0] tick_q;
	logic [AW-1:0]               oldest_q;
	logic [CW-1:0]               fill_q;
	logic [AW-1:0]               show_q;
	logic [CW-1:0]               scan_k_q;
	logic                        cmp_v_q;
	logic                        empty_q;
	logic [EW-1:0]               entry_q;

	logic                        out_valid_q;
	logic [15:0]                 out_data_q;

	// RAM side
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	delr_pkg::disp_t disp;
	delr_pkg::disp_t result;

	logic          full;
	logic          hit;
	logic          rotate_due;
	logic [AW-1:0] show_next;
	logic          out_free;

	// Map a position counted from the oldest entry onto a RAM slot.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
	                                           input logic [CW-1:0] k);
		logic [AW:0] sum;
		sum = (AW+1)'(oldest) + (AW+1)'(k);
		if (sum >= (AW+1)'(LOG_DEPTH)) begin
			sum = sum - (AW+1)'(LOG_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign full      = (fill_q == CW'(LOG_DEPTH));
	assign hit       = cmp_v_q && (ram_rdata == entry_q);

	// Rotation uses the counter as updated by the current item.
	assign rotate_due = (fill_q != '0) && (tick_q >= rotate_q);
	always_comb begin
		if (!rotate_due) begin
			show_next = show_q;
		end else if ((CW'(show_q) + CW'(1)) == fill_q) begin
			show_next = '0;
		end else begin
			show_next = show_q + AW'(1);
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Drive the RAM ports from the sequencer state.
	always_comb begin
		ram_we    = (state_q == ST_WRITE);
		ram_waddr = full ? oldest_q : slot_of(oldest_q, fill_q);
		ram_re    = 1'b0;
		ram_raddr = slot_of(oldest_q, scan_k_q);
		unique case (state_q)
			ST_SCAN: begin
				ram_re = !hit && (scan_k_q < fill_q);
			end
			ST_SHOW: begin
				ram_re    = (fill_q != '0);
				ram_raddr = slot_of(oldest_q, CW'(show_next));
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	delr_ram #(
		.WIDTH(EW),
		.DEPTH(LOG_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(entry_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	delr_disp #(
		.PLACE_BITS(PLACE_BITS),
		.KIND_BITS (KIND_BITS)
	) u_disp (
		.kind (ram_rdata[7:0]),
		.place(ram_rdata[15:8]),
		.disp (disp)
	);

	// An empty log shows nothing with green on.
	always_comb begin
		if (empty_q) begin
			result.code  = '0;
			result.green = 1'b1;
		end else begin
			result = disp;
		end
	end

	// Store the report as tag, text id, file id; tag is kind, place, line.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			entry_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_q <= delr_pkg::ROTATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rotate_q <= cfg_data;
		end
	end

	// Load a new result when it is ready, else drop the one taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			oldest_q    <= '0;
			fill_q      <= '0;
			show_q      <= '0;
			scan_k_q    <= '0;
			cmp_v_q     <= 1'b0;
			empty_q     <= 1'b1;
			out_data_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						scan_k_q <= '0;
						cmp_v_q  <= 1'b0;
						if (s_tuser[0] == delr_pkg::REQ_TICK) begin
							// saturate the tick counter at its top
							if (tick_q != delr_pkg::TICK_MAX) begin
								tick_q <= tick_q + 1'b1;
							end
							state_q <= ST_SHOW;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// compare the entry read last cycle while reading the next
					if (hit) begin
						state_q <= ST_SHOW;
					end else if (scan_k_q < fill_q) begin
						scan_k_q <= scan_k_q + 1'b1;
						cmp_v_q  <= 1'b1;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (full) begin
						// evict the oldest entry in place
						oldest_q <= (oldest_q == AW'(LOG_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (rotate_due) begin
						tick_q <= '0;
					end
					show_q  <= show_next;
					empty_q <= (fill_q == '0);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register can take the result
					if (out_free) begin
						out_data_q  <= {2'b00, delr_pkg::COUNT_W'(fill_q), result.green,
						                result.code};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
